[rtl/binary_morphology_3x3_multichannel_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the binary morphology unit
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BINARY_MORPHOLOGY_3X3_MULTICHANNEL_UNIT_DEFINES_SVH
`define BINARY_MORPHOLOGY_3X3_MULTICHANNEL_UNIT_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define BM3_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define BM3_ASSERT_NEVER(label, cond, msg) \
    `BM3_ASSERT_IMPLY(label, 1'b1, !(cond), msg)

`endif

[rtl/bm3_pkg.sv]
// ---------------------------------------------------------------------------
// bm3_pkg
// Shared constants and types for the 3x3 binary morphology unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bm3_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int CHANNELS     = 4;

    localparam int COL_W     = $clog2(MAX_WIDTH);       // column counter / line RAM address
    localparam int ROW_W     = $clog2(HEIGHT_LIMIT);    // row counter
    localparam int DIM_W     = 11;                      // frame_width / frame_height registers
    localparam int MASK_W    = 9;
    localparam int ACT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam int LINE_W    = 2 * CHANNELS;            // two stored rows per column
    localparam int WCOL_W    = 3 * CHANNELS;            // one 3-row window column
    localparam int TDATA_W   = ((CHANNELS + 7) / 8) * 8;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_STRUCT_MASK  = 3'd2,
        REG_EROSION_MODE = 3'd3,
        REG_ACTIVE_CHAN  = 3'd4
    } t_cfg_reg;

    // effective configuration as seen by the datapath
    typedef struct packed {
        logic [COL_W-1:0]  width_m1;
        logic [ROW_W-1:0]  height_m1;
        logic [MASK_W-1:0] smask;
        logic              erosion;
        logic [ACT_W-1:0]  active;
    } t_cfg;

    // one item in the RAM read stage
    typedef struct packed {
        logic                valid;
        t_kind               kind;
        logic [CHANNELS-1:0] bits;
        logic [COL_W-1:0]    addr;
        logic                emit;
        logic                border;
        logic                fend;
    } t_item;

endpackage

[rtl/bm3_line_ram.sv]
// ---------------------------------------------------------------------------
// bm3_line_ram
// Simple dual-port line RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bm3_line_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bm3_ctrl.sv]
// ---------------------------------------------------------------------------
// bm3_ctrl
// Raster counters, item classification, line RAM read issue, read stage reg.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bm3_ctrl import bm3_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_restart,      // size register written
    input  logic          i_valid,
    output logic          o_ready,
    input  t_kind         i_kind,
    input  logic [CHANNELS-1:0] i_bits,
    input  logic          i_b_go,         // read stage item consumed
    output t_item         o_item,
    output logic          o_ram_re,
    output logic [COL_W-1:0] o_ram_raddr
);

    logic [COL_W-1:0] r_in_x, n_in_x, r_out_x, n_out_x;
    logic [ROW_W-1:0] r_in_y, n_in_y, r_out_y, n_out_y;
    logic             r_in_done, n_in_done;
    t_item            r_b, n_b;

    logic pix_ok, fl_ok, accept, emit, fend, border;
    logic in_x_last, in_y_last, out_x_last, out_y_last;
    logic [COL_W-1:0] rd_addr;

    assign o_ready = !r_b.valid || i_b_go;
    assign accept  = i_valid && o_ready;

    always_comb begin
        in_x_last  = (r_in_x == i_cfg.width_m1);
        in_y_last  = (r_in_y == i_cfg.height_m1);
        out_x_last = (r_out_x == i_cfg.width_m1);
        out_y_last = (r_out_y == i_cfg.height_m1);

        pix_ok = (i_kind == KIND_PIXEL) && !r_in_done;
        fl_ok  = (i_kind == KIND_FLUSH) && r_in_done;
        // a pixel yields a result once width+1 pixels are in
        emit   = fl_ok || (pix_ok && ((r_in_y > ROW_W'(1)) ||
                                      ((r_in_y == ROW_W'(1)) && (r_in_x != '0))));
        border = (r_out_x == '0) || out_x_last || (r_out_y == '0) || out_y_last;
        fend   = out_x_last && out_y_last;

        // flush reads the column one ahead of the result column
        if (pix_ok) begin
            rd_addr = r_in_x;
        end else if (out_x_last) begin
            rd_addr = '0;
        end else begin
            rd_addr = r_out_x + COL_W'(1);
        end

        n_b.valid  = pix_ok || fl_ok;
        n_b.kind   = i_kind;
        n_b.bits   = i_bits;
        n_b.addr   = rd_addr;
        n_b.emit   = emit;
        n_b.border = border;
        n_b.fend   = fend;

        n_in_x    = r_in_x;
        n_in_y    = r_in_y;
        n_in_done = r_in_done;
        n_out_x   = r_out_x;
        n_out_y   = r_out_y;

        if (i_restart) begin
            n_in_x    = '0;
            n_in_y    = '0;
            n_in_done = 1'b0;
            n_out_x   = '0;
            n_out_y   = '0;
        end else if (accept) begin
            if (pix_ok) begin
                if (in_x_last && in_y_last) begin
                    n_in_x    = '0;
                    n_in_y    = '0;
                    n_in_done = 1'b1;
                end else if (in_x_last) begin
                    n_in_x = '0;
                    n_in_y = r_in_y + ROW_W'(1);
                end else begin
                    n_in_x = r_in_x + COL_W'(1);
                end
            end
            if (emit) begin
                if (fend) begin
                    n_in_x    = '0;
                    n_in_y    = '0;
                    n_in_done = 1'b0;
                    n_out_x   = '0;
                    n_out_y   = '0;
                end else if (out_x_last) begin
                    n_out_x = '0;
                    n_out_y = r_out_y + ROW_W'(1);
                end else begin
                    n_out_x = r_out_x + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_x    <= '0;
            r_in_y    <= '0;
            r_in_done <= 1'b0;
            r_out_x   <= '0;
            r_out_y   <= '0;
            r_b.valid <= 1'b0;
        end else begin
            r_in_x    <= n_in_x;
            r_in_y    <= n_in_y;
            r_in_done <= n_in_done;
            r_out_x   <= n_out_x;
            r_out_y   <= n_out_y;
            if (accept) begin
                r_b <= n_b;
            end else if (i_b_go) begin
                r_b.valid <= 1'b0;
            end
        end
    end

    assign o_item      = r_b;
    assign o_ram_re    = accept && n_b.valid;
    assign o_ram_raddr = rd_addr;

endmodule

[rtl/bm3_window.sv]
// ---------------------------------------------------------------------------
// bm3_window
// Column build, line RAM write-back, 3x3 window, kernel and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bm3_window import bm3_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_item               i_item,
    input  logic [LINE_W-1:0]   i_rdata,
    output logic                o_b_go,
    output logic                o_ram_we,
    output logic [COL_W-1:0]    o_ram_waddr,
    output logic [LINE_W-1:0]   o_ram_wdata,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHANNELS-1:0] o_bits,
    output logic                o_fend
);

    logic [WCOL_W-1:0]   r_win [3];
    logic [WCOL_W-1:0]   n_win [3];
    logic [WCOL_W-1:0]   col;
    logic                r_c_valid;
    logic [CHANNELS-1:0] r_c_bits, res;
    logic                r_c_fend;
    logic                c_free, pix;

    assign c_free = !r_c_valid || i_ready;
    assign o_b_go = i_item.valid && (!i_item.emit || c_free);
    assign pix    = (i_item.kind == KIND_PIXEL);

    // rows in a column: oldest low, newest (incoming) high
    assign col = {(pix ? i_item.bits : {CHANNELS{1'b0}}), i_rdata};

    assign o_ram_we    = o_b_go && pix;
    assign o_ram_waddr = i_item.addr;
    assign o_ram_wdata = {i_item.bits, i_rdata[LINE_W-1:CHANNELS]};

    always_comb begin
        logic [CHANNELS-1:0] center;
        logic hit, miss, tap;
        center   = r_win[2][2*CHANNELS-1:CHANNELS];
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = col;
        res      = center;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            hit  = 1'b0;
            miss = 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    tap = n_win[c][r*CHANNELS + ch];
                    if (i_cfg.smask[r*3 + c]) begin
                        hit  = hit | tap;
                        miss = miss | !tap;
                    end
                end
            end
            if (!i_item.border && (ACT_W'(ch) < i_cfg.active)) begin
                if (i_cfg.erosion) begin
                    if (miss) res[ch] = 1'b0;
                end else begin
                    if (hit) res[ch] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0]  <= '0;
            r_win[1]  <= '0;
            r_win[2]  <= '0;
            r_c_valid <= 1'b0;
        end else begin
            if (o_b_go) begin
                r_win[0] <= n_win[0];
                r_win[1] <= n_win[1];
                r_win[2] <= n_win[2];
            end
            if (o_b_go && i_item.emit) begin
                r_c_valid <= 1'b1;
                r_c_bits  <= res;
                r_c_fend  <= i_item.fend;
            end else if (i_ready) begin
                r_c_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_c_valid;
    assign o_bits  = r_c_bits;
    assign o_fend  = r_c_fend;

endmodule

[rtl/binary_morphology_3x3_multichannel_unit.sv]
// Pipeline: a beat passes the read stage register and then the output register;
//   the result of raster pixel p is caused by pixel p+width+1, or by a flush beat.
// Throughput: one beat per cycle unless the output blocks; the line RAM is read on accept and
//   written as the beat leaves the read stage, so a pixel and its neighbor column never touch the same entry.
// Reset (i_rst_n low, synchronous): counters, pipeline valids, window and
//   configuration return to defaults; line RAM contents are left as they are.
// ---------------------------------------------------------------------------
// binary_morphology_3x3_multichannel_unit
// Streaming 3x3 binary dilation/erosion over up to four mask channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_morphology_3x3_multichannel_unit_defines.svh"

module binary_morphology_3x3_multichannel_unit import bm3_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // [3:0] pixel_bits, rest zero
    input  logic [0:0]           s_axis_tuser,   // [0] kind
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [3:0] out_bits, rest zero
    output logic                 m_axis_tlast    // frame_end
);

    // configuration registers
    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;
    logic [MASK_W-1:0] r_struct_mask;
    logic              r_erosion_mode;
    logic [ACT_W-1:0]  r_active_chan;
    logic              cfg_restart;

    logic [DIM_W-1:0]  width_cl, height_cl;
    t_cfg              cfg;

    t_item               b_item;
    logic                b_go;
    logic                ram_re, ram_we;
    logic [COL_W-1:0]    ram_raddr, ram_waddr;
    logic [LINE_W-1:0]   ram_rdata, ram_wdata;
    logic [CHANNELS-1:0] out_bits;

    // width/height writes restart the slice
    always_comb begin
        cfg_restart = 1'b0;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_FRAME_WIDTH, REG_FRAME_HEIGHT: cfg_restart = 1'b1;
                default:                           cfg_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(512);
            r_frame_height <= DIM_W'(512);
            r_struct_mask  <= '1;
            r_erosion_mode <= 1'b0;
            r_active_chan  <= ACT_W'(4);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[DIM_W-1:0];
                REG_STRUCT_MASK:  r_struct_mask  <= i_cfg_wdata[MASK_W-1:0];
                REG_EROSION_MODE: r_erosion_mode <= i_cfg_wdata[0];
                REG_ACTIVE_CHAN:  r_active_chan  <= i_cfg_wdata[ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes are clamped to [3, limit]
    always_comb begin
        if (r_frame_width < DIM_W'(3)) begin
            width_cl = DIM_W'(3);
        end else if (r_frame_width > DIM_W'(MAX_WIDTH)) begin
            width_cl = DIM_W'(MAX_WIDTH);
        end else begin
            width_cl = r_frame_width;
        end
        if (r_frame_height < DIM_W'(3)) begin
            height_cl = DIM_W'(3);
        end else if (r_frame_height > DIM_W'(HEIGHT_LIMIT)) begin
            height_cl = DIM_W'(HEIGHT_LIMIT);
        end else begin
            height_cl = r_frame_height;
        end
    end

    logic [DIM_W-1:0] width_m1_full, height_m1_full;
    assign width_m1_full  = width_cl - DIM_W'(1);
    assign height_m1_full = height_cl - DIM_W'(1);

    assign cfg.width_m1  = width_m1_full[COL_W-1:0];
    assign cfg.height_m1 = height_m1_full[ROW_W-1:0];
    assign cfg.smask     = r_struct_mask;
    assign cfg.erosion   = r_erosion_mode;
    assign cfg.active    = r_active_chan;

    // counters, classification and RAM read issue
    bm3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_restart   (cfg_restart),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (t_kind'(s_axis_tuser[0])),
        .i_bits      (s_axis_tdata[CHANNELS-1:0]),
        .i_b_go      (b_go),
        .o_item      (b_item),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    // two previous rows per column
    bm3_line_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // window, kernel, write-back and output register
    bm3_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_item      (b_item),
        .i_rdata     (ram_rdata),
        .o_b_go      (b_go),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_bits      (out_bits),
        .o_fend      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(TDATA_W-CHANNELS){1'b0}}, out_bits};

    // write-back and the next read never hit the same column
    `BM3_ASSERT_NEVER(a_no_ram_collision, ram_we && ram_re && (ram_waddr == ram_raddr), "line RAM read/write collision")
    // only pixel beats leaving the read stage update the line RAM
    `BM3_ASSERT_IMPLY(a_we_from_pixel, ram_we, b_go && (b_item.kind == KIND_PIXEL), "line RAM written without a pixel")
    // input stalls only with both stages full and the output blocked
    `BM3_ASSERT_IMPLY(a_stall_cause, !s_axis_tready, b_item.valid && b_item.emit && m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

endmodule
